// ----- design/prrs_pkg.sv -----
`timescale 1ns / 1ps
package prrs_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_WAKE   = 2'd1,
    OP_WAIT   = 2'd2,
    OP_SELECT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_PRIORITY = 2'd1,
    ERR_EMPTY    = 2'd2
  } err_t;

  localparam logic [8:0] COUNT_MAX = 9'd511;
  localparam logic [8:0] TOTAL_MAX = 9'd256;

  typedef struct packed {
    op_t        operation;
    logic [7:0] thread_id;
    logic [7:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0] chosen_thread;
    logic       chosen_idle;
    err_t       error_code;
    logic [8:0] total_threads;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic scan_grp;
    logic scan_pick;
    logic rd_level;
    logic rd_link;
    logic exec;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic new_select;
    logic in_select;
    logic in_bad;
    logic found;
    logic out_free;
  } sts_t;

endpackage

// ----- design/priority_round_robin_scheduler_unit.sv -----
`timescale 1ns / 1ps
// Port group   Direction  Handshake          Beat contents
// in_*         input      in_valid/in_stall   operation, thread_id, priority_req
// out_*        output     out_valid/out_stall chosen_thread, chosen_idle, error_code,
//                                             total_threads
// cfg_*        input      cfg_we              idle_thread
//
// Add, wake and wait: level read, update, result load; a bad priority: result
// load only. Select: two-step level scan, level read, link read, update, result
// load; with no runnable level only the scan and the result load.
// One item is in work at a time; the output register lets the next beat be
// accepted while a result waits under out_stall.
// rst_n is synchronous; it empties every level and clears the thread total and
// idle_thread. Link tables have no reset.
module priority_round_robin_scheduler_unit #(
  parameter int PRIORITY_LEVELS = 64,
  parameter int THREAD_SLOTS    = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  prrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output prrs_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  prrs_pkg::cmd_t cmd;
  prrs_pkg::sts_t sts;

  prrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  prrs_dpath #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .THREAD_SLOTS    (THREAD_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- design/prrs_ctrl.sv -----
`timescale 1ns / 1ps
module prrs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  prrs_pkg::sts_t sts,
  output prrs_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_SCAN_GRP  = 7'b0000010,
    ST_SCAN_PICK = 7'b0000100,
    ST_LVL_RD    = 7'b0001000,
    ST_LINK_RD   = 7'b0010000,
    ST_EXEC      = 7'b0100000,
    ST_RESP      = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (sts.new_select) state_nxt = ST_SCAN_GRP;
          else if (sts.in_bad) state_nxt = ST_RESP;
          else state_nxt = ST_LVL_RD;
        end
      end
      ST_SCAN_GRP: begin
        cmd.scan_grp = 1'b1;
        state_nxt    = ST_SCAN_PICK;
      end
      ST_SCAN_PICK: begin
        cmd.scan_pick = 1'b1;
        state_nxt     = sts.found ? ST_LVL_RD : ST_RESP;
      end
      ST_LVL_RD: begin
        cmd.rd_level = 1'b1;
        // A select also needs the link behind the queue head.
        state_nxt    = sts.in_select ? ST_LINK_RD : ST_EXEC;
      end
      ST_LINK_RD: begin
        cmd.rd_link = 1'b1;
        state_nxt   = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("accepted beat did not start work");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a waiting beat");

  a_exec_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> ($past(cmd.rd_level) || $past(cmd.rd_link)))
    else $error("execute without fresh read data");

  a_pick_after_grp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_pick |-> $past(cmd.scan_grp))
    else $error("scan pick without group pass");

endmodule

// ----- design/prrs_dpath.sv -----
`timescale 1ns / 1ps
module prrs_dpath #(
  parameter int PRIORITY_LEVELS = 64,
  parameter int THREAD_SLOTS    = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  prrs_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  prrs_pkg::cmd_t      cmd,
  output prrs_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_stall,
  output prrs_pkg::out_item_t out_data
);

  localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int TW = $clog2(THREAD_SLOTS);
  localparam int NG = (PRIORITY_LEVELS + 15) / 16;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam logic [8:0] LEVELS_W = 9'(PRIORITY_LEVELS);

  logic [TW-1:0] head_mem [PRIORITY_LEVELS];
  logic [TW-1:0] tail_mem [PRIORITY_LEVELS];
  logic [TW-1:0] run_mem  [PRIORITY_LEVELS];
  logic [8:0]    cnt_mem  [PRIORITY_LEVELS];
  logic [TW-1:0] next_mem [THREAD_SLOTS];
  logic [TW-1:0] prev_mem [THREAD_SLOTS];

  logic [PRIORITY_LEVELS-1:0] qv_r, rv_r, nz_r;
  prrs_pkg::op_t  op_r;
  logic [TW-1:0]  tid_r;
  logic [LW-1:0]  lev_r;
  logic [TW-1:0]  head_rd_r, tail_rd_r, run_rd_r, nx_rd_r, pv_rd_r;
  logic [8:0]     cnt_rd_r;
  logic [7:0]     res_chosen_r;
  logic           res_idle_r;
  prrs_pkg::err_t res_err_r;
  logic [8:0]     total_r, total_nxt;
  logic [7:0]     idle_thread_r;
  logic [NG-1:0]  grp_any_r, grp_any_nxt;
  logic           out_valid_r;
  prrs_pkg::out_item_t out_data_r;

  // Input decode and thread index reduction.
  logic [19:0]   mod_v;
  logic [TW-1:0] in_tid;
  logic          in_bad;

  always_comb begin
    mod_v = 20'(in_data.thread_id);
    for (int k = 7; k >= 0; k--) begin
      if (mod_v >= (20'(THREAD_SLOTS) << k)) mod_v = mod_v - (20'(THREAD_SLOTS) << k);
    end
    in_tid = mod_v[TW-1:0];
    in_bad = ({1'b0, in_data.priority_req} >= LEVELS_W);
  end

  // Level scan: group flags first, then the first eligible level.
  logic [NG*16-1:0] elig;
  logic [GW-1:0]    sel_g;
  logic [15:0]      grp_bits;
  logic [3:0]       sel_j;
  logic [LW-1:0]    pick_lev;

  always_comb begin
    elig = '0;
    elig[PRIORITY_LEVELS-1:0] = nz_r & (qv_r | rv_r);
    for (int g = 0; g < NG; g++) grp_any_nxt[g] = |elig[g*16 +: 16];
    sel_g = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_r[g]) sel_g = GW'(g);
    end
    grp_bits = elig[sel_g*16 +: 16];
    sel_j = '0;
    for (int j = 15; j >= 0; j--) begin
      if (grp_bits[j]) sel_j = 4'(j);
    end
    pick_lev = LW'({sel_g, sel_j});
  end

  assign sts.new_select = (in_data.operation == prrs_pkg::OP_SELECT);
  assign sts.in_select  = (op_r == prrs_pkg::OP_SELECT);
  assign sts.in_bad     = in_bad;
  assign sts.found      = |grp_any_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  // Execute step for the latched operation.
  logic           qv, rv, ih, it;
  logic [8:0]     cnt_eff, ncnt;
  logic [TW-1:0]  nh, ntl, nrun, ex_chosen;
  logic           nqv, nrv, lvl_we;
  logic           nx_we, pv_we;
  logic [TW-1:0]  nx_wa, nx_wd, pv_wa, pv_wd;
  prrs_pkg::err_t ex_err;

  always_comb begin
    qv        = qv_r[lev_r];
    rv        = rv_r[lev_r];
    cnt_eff   = nz_r[lev_r] ? cnt_rd_r : 9'd0;
    ih        = (head_rd_r == tid_r);
    it        = (tail_rd_r == tid_r);
    nh        = head_rd_r;
    ntl       = tail_rd_r;
    nrun      = run_rd_r;
    ncnt      = cnt_eff;
    nqv       = qv;
    nrv       = rv;
    lvl_we    = 1'b0;
    nx_we     = 1'b0;
    pv_we     = 1'b0;
    nx_wa     = tid_r;
    nx_wd     = head_rd_r;
    pv_wa     = head_rd_r;
    pv_wd     = tid_r;
    ex_chosen = '0;
    ex_err    = prrs_pkg::ERR_OK;
    total_nxt = total_r;
    case (op_r)
      prrs_pkg::OP_ADD: begin
        lvl_we = 1'b1;
        if (qv) begin
          nx_we = 1'b1;
          pv_we = 1'b1;
        end else begin
          ntl = tid_r;
          nqv = 1'b1;
        end
        nh = tid_r;
        if (cnt_eff != prrs_pkg::COUNT_MAX) ncnt = cnt_eff + 9'd1;
        if (total_r != prrs_pkg::TOTAL_MAX) total_nxt = total_r + 9'd1;
      end
      prrs_pkg::OP_WAKE: begin
        lvl_we = 1'b1;
        if (qv) begin
          pv_we = 1'b1;
          pv_wa = tid_r;
          pv_wd = tail_rd_r;
          nx_we = 1'b1;
          nx_wa = tail_rd_r;
          nx_wd = tid_r;
        end else begin
          nh  = tid_r;
          nqv = 1'b1;
        end
        ntl = tid_r;
        if (cnt_eff != prrs_pkg::COUNT_MAX) ncnt = cnt_eff + 9'd1;
      end
      prrs_pkg::OP_WAIT: begin
        if (cnt_eff == 9'd0) begin
          ex_err = prrs_pkg::ERR_EMPTY;
        end else begin
          lvl_we = 1'b1;
          ncnt   = cnt_eff - 9'd1;
          if (rv && run_rd_r == tid_r) begin
            nrv = 1'b0;
          end else if (qv) begin
            if (ih && it) begin
              nqv = 1'b0;
            end else begin
              if (ih) begin
                nh = nx_rd_r;
              end else begin
                nx_we = 1'b1;
                nx_wa = pv_rd_r;
                nx_wd = nx_rd_r;
              end
              if (it) begin
                ntl = pv_rd_r;
              end else begin
                pv_we = 1'b1;
                pv_wa = nx_rd_r;
                pv_wd = pv_rd_r;
              end
            end
          end
        end
      end
      prrs_pkg::OP_SELECT: begin
        if (qv) begin
          // Pop the head, then put the old runner back at the tail.
          ex_chosen = head_rd_r;
          lvl_we    = 1'b1;
          nqv       = (tail_rd_r != head_rd_r);
          if (nqv) nh = nx_rd_r;
          if (rv) begin
            if (nqv) begin
              pv_we = 1'b1;
              pv_wa = run_rd_r;
              pv_wd = tail_rd_r;
              nx_we = 1'b1;
              nx_wa = tail_rd_r;
              nx_wd = run_rd_r;
            end else begin
              nh  = run_rd_r;
              nqv = 1'b1;
            end
            ntl = run_rd_r;
          end
          nrun = head_rd_r;
          nrv  = 1'b1;
        end else begin
          ex_chosen = run_rd_r;
        end
      end
      default: ex_err = prrs_pkg::ERR_OK;
    endcase
  end

  // Memories.
  logic [TW-1:0] link_ra;
  assign link_ra = cmd.rd_link ? head_rd_r : tid_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_level) begin
      head_rd_r <= head_mem[lev_r];
      tail_rd_r <= tail_mem[lev_r];
      run_rd_r  <= run_mem[lev_r];
      cnt_rd_r  <= cnt_mem[lev_r];
    end
    if (cmd.exec && lvl_we) begin
      head_mem[lev_r] <= nh;
      tail_mem[lev_r] <= ntl;
      run_mem[lev_r]  <= nrun;
      cnt_mem[lev_r]  <= ncnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_level || cmd.rd_link) begin
      nx_rd_r <= next_mem[link_ra];
      pv_rd_r <= prev_mem[link_ra];
    end
    if (cmd.exec && nx_we) next_mem[nx_wa] <= nx_wd;
    if (cmd.exec && pv_we) prev_mem[pv_wa] <= pv_wd;
  end

  // Item registers.
  always_ff @(posedge clk) begin
    if (cmd.scan_grp) grp_any_r <= grp_any_nxt;
    if (cmd.latch) begin
      op_r         <= in_data.operation;
      tid_r        <= in_tid;
      lev_r        <= LW'(in_data.priority_req);
      res_chosen_r <= 8'd0;
      res_idle_r   <= 1'b0;
      res_err_r    <= in_bad && (in_data.operation != prrs_pkg::OP_SELECT)
                      ? prrs_pkg::ERR_PRIORITY : prrs_pkg::ERR_OK;
    end
    if (cmd.scan_pick) begin
      lev_r <= pick_lev;
      if (!sts.found) begin
        res_chosen_r <= idle_thread_r;
        res_idle_r   <= 1'b1;
      end
    end
    if (cmd.exec) begin
      res_chosen_r <= 8'(ex_chosen);
      res_err_r    <= ex_err;
    end
    if (cmd.load_out) begin
      out_data_r.chosen_thread <= res_chosen_r;
      out_data_r.chosen_idle   <= res_idle_r;
      out_data_r.error_code    <= res_err_r;
      out_data_r.total_threads <= total_r;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r          <= '0;
      rv_r          <= '0;
      nz_r          <= '0;
      total_r       <= 9'd0;
      idle_thread_r <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.exec && lvl_we) begin
        qv_r[lev_r] <= nqv;
        rv_r[lev_r] <= nrv;
        nz_r[lev_r] <= (ncnt != 9'd0);
      end
      if (cmd.exec) total_r <= total_nxt;
      if (cfg_we) idle_thread_r <= cfg_wdata;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_total_sat: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= prrs_pkg::TOTAL_MAX)
    else $error("thread total beyond saturation");

  a_total_only_add: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != $past(total_r)) |-> ($past(cmd.exec) && $past(op_r) == prrs_pkg::OP_ADD))
    else $error("thread total moved outside an add");

  a_idle_flag_chosen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.chosen_idle) |-> (out_data_r.error_code == prrs_pkg::ERR_OK))
    else $error("idle pick carries an error");

endmodule
